@@ rtl/ilie_pkg.sv @@
package ilie_pkg;

	// Upper bound on the list capacity, and the index width that covers it.
	localparam int MaxCapacity = 1024;
	localparam int MaxIdxW     = $clog2(MaxCapacity);
	localparam int DefCapacity = 64;
	localparam int WordW       = 32;
	localparam int PosW        = 6;
	localparam int CountW      = 7;

	typedef enum logic [2:0] {
		REQ_PUSH   = 3'd0,
		REQ_POP    = 3'd1,
		REQ_READ   = 3'd2,
		REQ_WRITE  = 3'd3,
		REQ_INSERT = 3'd4,
		REQ_ERASE  = 3'd5,
		REQ_CLEAR  = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// What every cell of the row does in the current cycle.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_ERASE  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [MaxIdxW-1:0] tgt;
		logic [WordW-1:0]   word;
	} cell_ctrl_t;

endpackage

@@ rtl/ilie_cell.sv @@
module ilie_cell
	import ilie_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [WordW-1:0] prev_word,
	input  logic [WordW-1:0] next_word,
	output logic [WordW-1:0] word
);

	logic [WordW-1:0] word_q;
	logic             at_tgt;
	logic             above_tgt;

	assign at_tgt    = (MaxIdxW'(IDX) == ctrl.tgt);
	assign above_tgt = (MaxIdxW'(IDX) > ctrl.tgt);

	// Insert moves the entry up from the cell below; erase pulls it down from the cell above.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_WRITE: begin
				if (at_tgt) word_q <= ctrl.word;
			end
			CELL_INSERT: begin
				if (at_tgt) word_q <= ctrl.word;
				else if (above_tgt) word_q <= prev_word;
			end
			CELL_ERASE: begin
				if (at_tgt || above_tgt) word_q <= next_word;
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;

endmodule

@@ rtl/indexed_list_insert_erase.sv @@
// Bounded ordered list of signed 32-bit words, held in a row of cells.
// Request channel: in_valid / in_stall carry one beat with req_type, position
// and data_in. Result channel: out_valid / out_stall carry one beat with
// read_value, status, count and is_empty for every request, in order.
// Each request is finished in the cycle it is accepted: insert shifts the
// entries from the index up and erase pulls those above it down, one place
// at the same clock edge, so the result appears in the cycle after acceptance
// and a new request can be taken every cycle while the receiver does not
// stall. The rate is set by the single result register, which holds its beat
// on a stall while in_stall rises, so no request is taken until it has gone.
// Reset clears the fill count and the result valid flag; the cell contents
// are not cleared, since no entry at or above the count is ever read.
// Positions reach entries 0 to 63 only; the count port shows the low seven
// bits of the fill count.
module indexed_list_insert_erase
	import ilie_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               req_type,
	input  logic [PosW-1:0]          position,
	input  logic signed [WordW-1:0]  data_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WordW-1:0]  read_value,
	output logic [1:0]               status,
	output logic [CountW-1:0]        count,
	output logic                     is_empty
);

	// Fill count width must hold CAPACITY itself.
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > PosW) ? CW : PosW;
	// Only the cells that a position can reach feed the read path.
	localparam int RN   = (CAPACITY < (1 << PosW)) ? CAPACITY : (1 << PosW);

	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     fill_nxt;
	logic              out_valid_q;
	logic [WordW-1:0]  read_value_q;
	status_t           status_q;
	logic [CountW-1:0] count_q;
	logic              is_empty_q;

	logic              accept;
	logic              in_range;
	logic              full;
	logic [WordW-1:0]  rd_word;
	logic [WordW-1:0]  rv_nxt;
	status_t           st_nxt;
	cell_ctrl_t        ctrl;
	logic [WordW-1:0]  cell_word [CAPACITY];

	// A request is taken whenever the result register is free or is being
	// emptied in this very cycle.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign in_range = (CMPW'(position) < CMPW'(fill_q));
	assign full     = (fill_q == CW'(CAPACITY));

	// Read path: each reachable cell is gated by its own index match and
	// the results are ORed together.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < RN; i++) begin
			if (position == PosW'(i)) rd_word = rd_word | cell_word[i];
		end
	end

	// Request decode. Cells only see a non-hold operation on an accepted
	// request that passes its checks.
	always_comb begin
		fill_nxt  = fill_q;
		rv_nxt    = '0;
		st_nxt    = ST_OK;
		ctrl.op   = CELL_HOLD;
		ctrl.tgt  = MaxIdxW'(position);
		ctrl.word = data_in;
		case (req_type)
			REQ_PUSH: begin
				if (full) begin
					st_nxt = ST_FULL;
				end else begin
					ctrl.op  = CELL_WRITE;
					ctrl.tgt = MaxIdxW'(fill_q);
					fill_nxt = fill_q + CW'(1);
				end
			end
			REQ_POP: begin
				if (fill_q == '0) st_nxt = ST_EMPTY;
				else fill_nxt = fill_q - CW'(1);
			end
			REQ_READ: begin
				if (!in_range) st_nxt = ST_RANGE;
				else rv_nxt = rd_word;
			end
			REQ_WRITE: begin
				if (!in_range) st_nxt = ST_RANGE;
				else ctrl.op = CELL_WRITE;
			end
			REQ_INSERT: begin
				// The index is checked before fullness.
				if (!in_range) begin
					st_nxt = ST_RANGE;
				end else if (full) begin
					st_nxt = ST_FULL;
				end else begin
					ctrl.op  = CELL_INSERT;
					fill_nxt = fill_q + CW'(1);
				end
			end
			REQ_ERASE: begin
				if (!in_range) begin
					st_nxt = ST_RANGE;
				end else begin
					ctrl.op  = CELL_ERASE;
					fill_nxt = fill_q - CW'(1);
				end
			end
			REQ_CLEAR: begin
				fill_nxt = '0;
			end
			default: begin
			end
		endcase
		if (!accept) ctrl.op = CELL_HOLD;
	end

	// Row of cells: each sees its neighbours, or zero past an end.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [WordW-1:0] prev_w;
		logic [WordW-1:0] next_w;
		if (g == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_lo
			assign prev_w = cell_word[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_hi
			assign next_w = cell_word[g+1];
		end
		ilie_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.prev_word(prev_w),
			.next_word(next_w),
			.word     (cell_word[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) fill_q <= fill_nxt;
			if (accept) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Result payload; it only moves when a new request is taken, so a
	// stalled beat holds.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rv_nxt;
			status_q     <= st_nxt;
			count_q      <= CountW'(fill_nxt);
			is_empty_q   <= (fill_nxt == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = count_q;
	assign is_empty   = is_empty_q;

endmodule

@@ rtl/ilie_chk.sv @@
module ilie_chk
	import ilie_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WordW-1:0]  read_value,
	input logic [1:0]        status,
	input logic [CountW-1:0] count,
	input logic              is_empty
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status)
			&& $stable(count))
		else $error("result beat changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)))
		else $error("empty flag disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count == CountW'(CAPACITY))
		else $error("full status with list not full");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> is_empty)
		else $error("empty status with entries present");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != '0 |-> status == ST_OK)
		else $error("read value on failed request");

endmodule

bind indexed_list_insert_erase ilie_chk #(
	.CAPACITY(CAPACITY)
) u_ilie_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_value(read_value),
	.status    (status),
	.count     (count),
	.is_empty  (is_empty)
);
